FILE: rtl/csv_field_row_tokenizer_unit_assert.svh
// Assertion macros for the CSV tokenizer RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef CSV_FIELD_ROW_TOKENIZER_UNIT_ASSERT_SVH
`define CSV_FIELD_ROW_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CSVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSVT_ASSERT(lbl, prop, msg)
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/csvt_pkg.sv
// Shared types and constants for the CSV field/row tokenizer.
// No dependencies.
package csvt_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_SKIP  = 2'd1,
    OP_FLUSH = 2'd2
  } csvt_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIMITER  = 3'd0,
    REG_QUOTE      = 3'd1,
    REG_SELECT_ALL = 3'd2,
    REG_COL_MASK   = 3'd3,
    REG_BATCH_ROWS = 3'd4
  } csvt_reg_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } csvt_in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [15:0] column_index;
    logic        field_end;
    logic        row_end;
    logic        batch_ready;
    logic        open_quote_error;
  } csvt_out_t;

  typedef struct packed {
    logic [7:0]  delimiter_char;
    logic [7:0]  quote_char;
    logic        select_all;
    logic [15:0] batch_rows;
  } csvt_cfg_t;

endpackage

FILE: rtl/csvt_cfg_regs.sv
// Configuration registers of the CSV tokenizer: delimiter, quote, column select, batch size.
// Depends on csvt_pkg.
module csvt_cfg_regs import csvt_pkg::*; #(
  parameter int unsigned MASK_COLUMNS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output csvt_cfg_t               cfg_o,
  output logic [MASK_COLUMNS-1:0] mask_o
);

  csvt_cfg_t               cfg_q;
  logic [MASK_COLUMNS-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_char <= 8'd44;
      cfg_q.quote_char     <= 8'd34;
      cfg_q.select_all     <= 1'b1;
      cfg_q.batch_rows     <= 16'd1024;
      mask_q               <= '1;
    end else if (cfg_we_i) begin
      unique case (csvt_reg_e'(cfg_idx_i))
        REG_DELIMITER:  cfg_q.delimiter_char <= cfg_data_i[7:0];
        REG_QUOTE:      cfg_q.quote_char     <= cfg_data_i[7:0];
        REG_SELECT_ALL: cfg_q.select_all     <= cfg_data_i[0];
        REG_COL_MASK:   mask_q               <= cfg_data_i[MASK_COLUMNS-1:0];
        REG_BATCH_ROWS: cfg_q.batch_rows     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o  = cfg_q;
  assign mask_o = mask_q;

endmodule

FILE: rtl/csvt_parse_core.sv
// Parse state machine of the CSV tokenizer: one item per enabled cycle.
// Holds mode, column and row counters; depends on csvt_pkg.
module csvt_parse_core import csvt_pkg::*; #(
  parameter int unsigned MASK_COLUMNS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_en_i,
  input  csvt_in_t                item_i,
  input  csvt_cfg_t               cfg_i,
  input  logic [MASK_COLUMNS-1:0] mask_i,
  output csvt_out_t               result_o,
  output logic                    has_result_o
);

  localparam int unsigned MASK_IDX_W = (MASK_COLUMNS > 1) ? $clog2(MASK_COLUMNS) : 1;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_AFTER  = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] col_q, col_d;
  logic [15:0] rows_q, rows_d;
  logic        acr_q, acr_d;
  logic        skip_q, skip_d;
  logic        rhf_q, rhf_d;

  logic [7:0]  b;
  logic        is_q, is_d, is_nl;
  logic        col_sel, emit_ok;
  logic        do_content, do_ef, do_er, do_flush, flush_err;
  logic        row_emit, batch_hit, flush_batch;
  logic [15:0] lim;
  logic [16:0] rows_inc;

  assign b     = item_i.data_byte;
  assign is_q  = (b == cfg_i.quote_char);
  assign is_d  = (b == cfg_i.delimiter_char);
  assign is_nl = (b == CH_CR) || (b == CH_LF);

  assign col_sel = cfg_i.select_all ||
                   ((col_q < 16'(MASK_COLUMNS)) && mask_i[col_q[MASK_IDX_W-1:0]]);
  assign emit_ok = !skip_q && col_sel;

  assign lim      = (cfg_i.batch_rows == 16'd0) ? 16'd1 : cfg_i.batch_rows;
  assign rows_inc = {1'b0, rows_q} + 17'd1;

  always_comb begin
    mode_d      = mode_q;
    col_d       = col_q;
    rows_d      = rows_q;
    acr_d       = acr_q;
    skip_d      = skip_q;
    rhf_d       = rhf_q;
    do_content  = 1'b0;
    do_ef       = 1'b0;
    do_er       = 1'b0;
    do_flush    = 1'b0;
    flush_err   = 1'b0;
    row_emit    = 1'b0;
    batch_hit   = 1'b0;
    flush_batch = 1'b0;

    if (step_en_i) begin
      unique case (csvt_op_e'(item_i.op))
        OP_DATA: begin
          acr_d = 1'b0;
          // drop the LF of a CR LF pair
          if (!(acr_q && b == CH_LF)) begin
            rhf_d = 1'b1;
            unique case (mode_q)
              MODE_START: begin
                if (is_q) begin
                  mode_d = MODE_QUOTED;
                end else if (is_d) begin
                  do_ef = 1'b1;
                end else if (is_nl) begin
                  do_ef = 1'b1;
                  do_er = 1'b1;
                  acr_d = (b == CH_CR);
                end else begin
                  mode_d     = MODE_PLAIN;
                  do_content = 1'b1;
                end
              end
              MODE_PLAIN: begin
                if (is_d) begin
                  do_ef = 1'b1;
                end else if (is_nl) begin
                  do_ef = 1'b1;
                  do_er = 1'b1;
                  acr_d = (b == CH_CR);
                end else begin
                  do_content = 1'b1;
                end
              end
              MODE_QUOTED: begin
                if (is_q) mode_d = MODE_AFTER;
                else      do_content = 1'b1;
              end
              MODE_AFTER: begin
                // doubled quote gives one quote byte
                if (is_q) begin
                  do_content = 1'b1;
                  mode_d     = MODE_QUOTED;
                end else if (is_d) begin
                  do_ef = 1'b1;
                end else if (is_nl) begin
                  do_ef = 1'b1;
                  do_er = 1'b1;
                  acr_d = (b == CH_CR);
                end else begin
                  mode_d     = MODE_PLAIN;
                  do_content = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        OP_SKIP: skip_d = 1'b1;
        OP_FLUSH: begin
          if (mode_q == MODE_QUOTED) begin
            flush_err = 1'b1;
          end else begin
            do_flush = 1'b1;
            if (mode_q != MODE_START || rhf_q) begin
              do_ef = 1'b1;
              do_er = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_ef) begin
      col_d  = (col_q != 16'hFFFF) ? col_q + 16'd1 : col_q;
      mode_d = MODE_START;
    end

    if (do_er) begin
      col_d  = 16'd0;
      rhf_d  = 1'b0;
      mode_d = MODE_START;
      if (skip_q) begin
        skip_d = 1'b0;
      end else begin
        row_emit = 1'b1;
        if (rows_inc >= {1'b0, lim}) begin
          batch_hit = 1'b1;
          rows_d    = 16'd0;
        end else begin
          rows_d = rows_inc[15:0];
        end
      end
    end

    if (do_flush) begin
      if (rows_d != 16'd0) begin
        flush_batch = 1'b1;
        rows_d      = 16'd0;
      end
      acr_d  = 1'b0;
      mode_d = MODE_START;
    end
  end

  always_comb begin
    result_o.byte_valid       = do_content && emit_ok;
    result_o.out_byte         = (do_content && emit_ok) ? b : 8'd0;
    result_o.field_end        = do_ef && emit_ok;
    result_o.column_index     = ((do_content || do_ef) && emit_ok) ? col_q : 16'd0;
    result_o.row_end          = row_emit;
    result_o.batch_ready      = batch_hit || flush_batch;
    result_o.open_quote_error = flush_err;
  end

  assign has_result_o = result_o.byte_valid || result_o.field_end || result_o.row_end ||
                        result_o.batch_ready || result_o.open_quote_error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      col_q  <= 16'd0;
      rows_q <= 16'd0;
      acr_q  <= 1'b0;
      skip_q <= 1'b0;
      rhf_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      col_q  <= col_d;
      rows_q <= rows_d;
      acr_q  <= acr_d;
      skip_q <= skip_d;
      rhf_q  <= rhf_d;
    end
  end

endmodule

FILE: rtl/csv_field_row_tokenizer_unit.sv
// CSV field/row tokenizer, one byte or command per clock unless the output stalls. Takes one
// item per cycle while the result register can advance; an item passes the input register,
// the parse update and the result register, and the parse-state update sets the rate. Items that yield no result
// produce no output transfer. Depends on csvt_pkg, csvt_cfg_regs, csvt_parse_core.
`include "csv_field_row_tokenizer_unit_assert.svh"
module csv_field_row_tokenizer_unit import csvt_pkg::*; #(
  parameter int unsigned MASK_COLUMNS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csvt_in_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvt_out_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  csvt_cfg_t               cfg;
  logic [MASK_COLUMNS-1:0] mask;

  logic      in_valid_q, in_valid_d;
  csvt_in_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  csvt_out_t out_item_q;
  csvt_out_t result;
  logic      has_result;
  logic      out_adv, proc, in_take;

  csvt_cfg_regs #(.MASK_COLUMNS(MASK_COLUMNS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .mask_o     (mask)
  );

  csvt_parse_core #(.MASK_COLUMNS(MASK_COLUMNS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (proc),
    .item_i       (in_item_q),
    .cfg_i        (cfg),
    .mask_i       (mask),
    .result_o     (result),
    .has_result_o (has_result)
  );

  // advance the result register when it is empty or its transfer completes
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (proc ? 1'b0 : in_valid_q);
  assign out_valid_d = out_adv ? (proc && has_result) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_item_i;
    if (out_adv) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `CSVT_ASSERT(a_result_not_empty, !out_valid_q || out_item_q.byte_valid || out_item_q.field_end || out_item_q.row_end || out_item_q.batch_ready || out_item_q.open_quote_error, "empty result transferred")
  `CSVT_ASSERT(a_error_alone, !(out_valid_q && out_item_q.open_quote_error) || !(out_item_q.byte_valid || out_item_q.field_end || out_item_q.row_end || out_item_q.batch_ready), "quote error mixed with other flags")
  `CSVT_ASSERT(a_byte_or_end, !(out_valid_q && out_item_q.byte_valid && out_item_q.field_end), "content byte and field end together")
  `CSVT_ASSERT_NEXT(a_hold_input, in_valid_q && !out_adv, in_valid_q && $stable(in_item_q), "stalled input item lost")
  `CSVT_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall_i, out_valid_q && $stable(out_item_q), "stalled result lost")

endmodule

FILE: tb/sv/csv_field_row_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for csv_field_row_tokenizer_unit: streams CSV bytes and
// commands through the valid/stall channels and checks every emitted token.
// Depends on csvt_pkg and the tokenizer RTL.
module csv_field_row_tokenizer_unit_tb;
  import csvt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MASK_COLUMNS = 64;

  typedef enum logic [1:0] {PM_START, PM_PLAIN, PM_QUOTED, PM_AFTER} parse_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  csvt_in_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  csvt_out_t             out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // register shadow
  logic [7:0]  cfg_delim = 8'd44;
  logic [7:0]  cfg_quote = 8'd34;
  logic        cfg_sel_all = 1'b1;
  logic [63:0] cfg_mask = '1;
  logic [15:0] cfg_batch = 16'd1024;

  // tokenizer state
  parse_mode_e tok_mode = PM_START;
  logic [15:0] col_pos = '0;
  logic        cr_seen = 1'b0;
  logic        skip_armed = 1'b0;
  logic        row_open = 1'b0;
  int unsigned rows_pending = 0;

  csvt_in_t    byte_stream_q[$];
  csvt_out_t   token_q[$];
  int unsigned queued = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned in_calm = 0;
  int unsigned out_calm = 0;

  csv_field_row_tokenizer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit col_selected(logic [15:0] col);
    if (cfg_sel_all) return 1'b1;
    if (col >= MASK_COLUMNS) return 1'b0;
    return cfg_mask[col[5:0]];
  endfunction

  function automatic void emit_content(logic [7:0] b, inout csvt_out_t r);
    if (!skip_armed && col_selected(col_pos)) begin
      r.byte_valid = 1'b1;
      r.out_byte = b;
      r.column_index = col_pos;
    end
  endfunction

  function automatic void close_field(inout csvt_out_t r);
    if (!skip_armed && col_selected(col_pos)) begin
      r.field_end = 1'b1;
      r.column_index = col_pos;
    end
    if (col_pos != 16'hFFFF) col_pos++;
    tok_mode = PM_START;
  endfunction

  function automatic void close_row(inout csvt_out_t r);
    int unsigned lim;
    lim = (cfg_batch == 0) ? 1 : cfg_batch;
    if (skip_armed) begin
      skip_armed = 1'b0;
    end else begin
      r.row_end = 1'b1;
      rows_pending++;
      if (rows_pending >= lim) begin
        r.batch_ready = 1'b1;
        rows_pending = 0;
      end
    end
    col_pos = '0;
    row_open = 1'b0;
    tok_mode = PM_START;
  endfunction

  function automatic void take_byte(logic [7:0] b, inout csvt_out_t r);
    if (cr_seen) begin
      cr_seen = 1'b0;
      // swallow the LF of a CR LF pair
      if (b == CH_LF) return;
    end
    row_open = 1'b1;
    if (tok_mode == PM_QUOTED) begin
      if (b == cfg_quote) tok_mode = PM_AFTER;
      else emit_content(b, r);
    end else if (tok_mode != PM_PLAIN && b == cfg_quote) begin
      // a quote right after a closing quote is an escaped quote byte
      if (tok_mode == PM_AFTER) emit_content(b, r);
      tok_mode = PM_QUOTED;
    end else if (b == cfg_delim) begin
      close_field(r);
    end else if (b == CH_CR || b == CH_LF) begin
      close_field(r);
      close_row(r);
      cr_seen = (b == CH_CR);
    end else begin
      tok_mode = PM_PLAIN;
      emit_content(b, r);
    end
  endfunction

  function automatic void flush_input(inout csvt_out_t r);
    if (tok_mode == PM_QUOTED) begin
      r.open_quote_error = 1'b1;
    end else begin
      if (tok_mode != PM_START || row_open) begin
        close_field(r);
        close_row(r);
      end
      if (rows_pending > 0) begin
        r.batch_ready = 1'b1;
        rows_pending = 0;
      end
      cr_seen = 1'b0;
      tok_mode = PM_START;
    end
  endfunction

  function automatic void predict_token(csvt_in_t it);
    csvt_out_t r;
    r = '0;
    case (it.op)
      OP_DATA:  take_byte(it.data_byte, r);
      OP_SKIP:  skip_armed = 1'b1;
      OP_FLUSH: flush_input(r);
      default: ;
    endcase
    if (r.byte_valid || r.field_end || r.row_end || r.batch_ready || r.open_quote_error)
      token_q.insert(token_q.size(), r);
  endfunction

  // mostly random waits, with runs of back-to-back cycles now and then
  function automatic int unsigned draw_idle(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      predict_token(in_item_i);
      gap = draw_idle(in_calm);
      if (gap == 0 && byte_stream_q.size() != 0) begin
        in_item_i <= byte_stream_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        gap_left <= (gap == 0) ? 0 : gap - 1;
      end
    end else if (!in_valid_i) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (byte_stream_q.size() != 0) begin
        in_item_i <= byte_stream_q.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    csvt_out_t   exp_tok;
    int unsigned hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected transfer: %p", out_item_o);
        mismatches++;
      end else begin
        exp_tok = token_q.pop_front();
        check_field("byte_valid", exp_tok.byte_valid, out_item_o.byte_valid);
        check_field("out_byte", exp_tok.out_byte, out_item_o.out_byte);
        check_field("column_index", exp_tok.column_index, out_item_o.column_index);
        check_field("field_end", exp_tok.field_end, out_item_o.field_end);
        check_field("row_end", exp_tok.row_end, out_item_o.row_end);
        check_field("batch_ready", exp_tok.batch_ready, out_item_o.batch_ready);
        check_field("open_quote_error", exp_tok.open_quote_error,
                    out_item_o.open_quote_error);
      end
      hold = draw_idle(out_calm);
      out_stall_i <= (hold != 0);
      stall_left <= hold;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_item(logic [1:0] op, logic [7:0] b);
    csvt_in_t it;
    it.op = op;
    it.data_byte = b;
    byte_stream_q.insert(byte_stream_q.size(), it);
    queued++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(OP_DATA, s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cfg_delim || b == cfg_quote || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  task automatic queue_row();
    int unsigned n_fields, kind, pick;
    bit          wide;
    wide = ($urandom_range(0, 24) == 0);
    n_fields = wide ? $urandom_range(64, 70) : $urandom_range(1, 6);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) queue_item(OP_DATA, cfg_delim);
      // wide rows stay mostly empty except the first fields and those around the mask boundary
      kind = (wide && f > 5 && (f < 62 || f > 66)) ? 0 : $urandom_range(0, 3);
      case (kind)
        1: repeat ($urandom_range(1, 4)) queue_item(OP_DATA, plain_byte());
        2, 3: begin
          queue_item(OP_DATA, cfg_quote);
          repeat ($urandom_range(0, 5)) begin
            pick = $urandom_range(0, 39);
            if (pick < 6) begin
              queue_item(OP_DATA, cfg_quote);
              queue_item(OP_DATA, cfg_quote);
            end else if (pick < 9) queue_item(OP_DATA, cfg_delim);
            else if (pick < 12) queue_item(OP_DATA, CH_CR);
            else if (pick < 15) queue_item(OP_DATA, CH_LF);
            else if (pick == 15) queue_item(OP_FLUSH, 8'($urandom));
            else queue_item(OP_DATA, plain_byte());
          end
          queue_item(OP_DATA, cfg_quote);
          if (kind == 3) repeat ($urandom_range(1, 2)) queue_item(OP_DATA, plain_byte());
        end
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) queue_item(OP_SKIP, 8'($urandom));
    end
    case ($urandom_range(0, 2))
      0: queue_item(OP_DATA, CH_CR);
      1: queue_item(OP_DATA, CH_LF);
      default: begin
        queue_item(OP_DATA, CH_CR);
        queue_item(OP_DATA, CH_LF);
      end
    endcase
  endtask

  // wait until every transfer is in and checked, then let the pipeline empty
  task automatic drain_pipeline();
    do @(negedge clk_i);
    while (byte_stream_q.size() != 0 || in_valid_i || token_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(csvt_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DELIMITER:  cfg_delim = val[7:0];
      REG_QUOTE:      cfg_quote = val[7:0];
      REG_SELECT_ALL: cfg_sel_all = val[0];
      REG_COL_MASK:   cfg_mask = val;
      REG_BATCH_ROWS: cfg_batch = val[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] delim, logic [7:0] quote, logic sel_all,
                           logic [63:0] mask, logic [15:0] batch);
    write_reg(REG_DELIMITER, 64'(delim));
    write_reg(REG_QUOTE, 64'(quote));
    write_reg(REG_SELECT_ALL, 64'(sel_all));
    write_reg(REG_COL_MASK, mask);
    write_reg(REG_BATCH_ROWS, 64'(batch));
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned first, pick;
    @(negedge clk_i);
    first = queued;
    while (queued - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) queue_row();
      else if (pick < 87) queue_item(OP_SKIP, 8'($urandom));
      else if (pick < 92) queue_item(OP_FLUSH, 8'($urandom));
      else if (pick < 97) queue_item(OP_DATA, 8'($urandom));
      else queue_item(OP_UNUSED, 8'($urandom));
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed pass on reset settings
    queue_text("a,b\015\012");
    queue_text("\"\"\"\"z,");
    queue_text("q\"\012\012");
    queue_item(OP_SKIP, 8'h00);
    queue_text("\377,\015");
    queue_item(OP_DATA, 8'h00);
    queue_item(OP_FLUSH, 8'hFF);
    queue_text("\"a");
    queue_item(OP_FLUSH, 8'h00);
    queue_text("\"");
    queue_item(OP_FLUSH, 8'h00);
    queue_item(OP_UNUSED, 8'hA5);
    drain_pipeline();

    configure(8'd59, 8'd39, 1'b0, {$urandom, $urandom}, 16'd1);
    run_random(125);
    configure(8'd0, 8'd255, 1'b0, '1, 16'd65535);
    run_random(125);
    configure(8'd255, 8'd0, 1'b1, 64'd0, 16'd0);
    run_random(125);
    configure(8'd34, 8'd34, 1'b0, {$urandom, $urandom}, 16'd3);
    run_random(125);
    configure(CH_CR, CH_LF, 1'b1, {$urandom, $urandom}, 16'd2);
    run_random(125);
    configure(8'd44, 8'd34, 1'b1, '1, 16'd7);
    run_random(125);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
